>>> rtl/core/lsmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lsmf_pkg;

   // Widths of the transaction fields.
   localparam int unsigned VALUE_W  = 16;
   localparam int unsigned COUNT_W  = 13;

   // The prime count saturates here.
   localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

   // Reset value of the sieve limit register.
   localparam logic [VALUE_W-1:0] SIEVE_LIMIT_RESET = 16'd65535;

   // The sieve starts at the first prime.
   localparam logic [VALUE_W-1:0] FIRST_PRIME = 16'd2;

   typedef enum logic [0:0] {
      OP_BUILD = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_RANGE   = 2'd1,
      STATUS_UNBUILT = 2'd2
   } status_type;

endpackage

`default_nettype wire

>>> rtl/core/lsmf_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one build or query transaction.
interface lsmf_req_if;
   logic                                valid;
   logic                                ready;
   lsmf_pkg::opcode_type                opcode;
   logic [lsmf_pkg::VALUE_W-1:0]        query_value;

   modport source (output valid, output opcode, output query_value, input ready);
   modport sink   (input valid, input opcode, input query_value, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lsmf_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Response channel: one result transaction per request.
interface lsmf_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [lsmf_pkg::VALUE_W-1:0]        smallest_factor;
   logic                                is_prime;
   logic [lsmf_pkg::COUNT_W-1:0]        prime_total;
   lsmf_pkg::status_type                status;

   modport source (output valid, output smallest_factor, output is_prime,
                   output prime_total, output status, input ready);
   modport sink   (input valid, input smallest_factor, input is_prime,
                   input prime_total, input status, output ready);
endinterface

`default_nettype wire

>>> rtl/core/lsmf_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port memory: one write port, one read port with registered
// read data that holds its value while no read is enabled.
module lsmf_ram #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned WIDTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/linear_sieve_min_factor.sv
`timescale 1ns / 1ps
`default_nettype none

// Query: an accepted value reads the factor table; the result loads the response register, or
// waits until it frees up. Error queries skip the read. Build with limit L: clear entries 2..L,
// then read and check each value, with one shared multiplier and compare per prime-list step.
// The block accepts no transaction while a build or query is in progress.
// Reset is synchronous, active high: control state and counts are cleared, the limit register
// returns to 65535, and the tables are kept, since a query before the first build is refused.

module linear_sieve_min_factor #(
   parameter int unsigned MAX_VALUE   = 65535,
   parameter int unsigned PRIME_SLOTS = 8192
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   lsmf_req_if.sink                             req_bus,
   lsmf_rsp_if.source                           rsp_bus,
   input  wire logic                            csr_write_en,
   input  wire logic [lsmf_pkg::VALUE_W-1:0]    csr_write_data
);

   // Width of a table value, of a prime-list address and of the stored-prime counter.
   localparam int unsigned VW = $clog2(MAX_VALUE + 1);
   localparam int unsigned SW = $clog2(PRIME_SLOTS);
   localparam int unsigned CW = $clog2(PRIME_SLOTS + 1);
   // Width in which the 16-bit fields and the table values can be compared.
   localparam int unsigned LW = (VW > lsmf_pkg::VALUE_W) ? VW : lsmf_pkg::VALUE_W;
   localparam int unsigned CNT_W = lsmf_pkg::COUNT_W;

   // The sequencer. A build first clears entries 2..L of the factor table, then visits
   // each value i: it reads the table entry of i, records i as a prime when the entry is
   // still zero, and then walks the prime list. Each step reads one prime p, forms p*i
   // in the shared multiplier and, when the product is within the limit, marks it with
   // p. The walk stops after the product passes the limit, after p reaches the smallest
   // factor of i, or at the end of the stored primes.
   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_CLEAR     = 9'b000000010,
      S_VISIT_RD  = 9'b000000100,
      S_VISIT_CHK = 9'b000001000,
      S_LIST_RD   = 9'b000010000,
      S_MUL       = 9'b000100000,
      S_MARK      = 9'b001000000,
      S_QUERY_RD  = 9'b010000000,
      S_SEND      = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration and build results.
   logic [lsmf_pkg::VALUE_W-1:0] sieve_limit_ff, sieve_limit_in;
   logic [VW-1:0]                built_limit_ff, built_limit_in;
   logic                         table_ready_ff, table_ready_in;
   logic [CNT_W-1:0]             prime_count_ff, prime_count_in;

   // Build working registers.
   logic [VW-1:0]                lim_ff, lim_in;
   logic [VW-1:0]                idx_ff, idx_in;
   logic [VW-1:0]                fac_ff, fac_in;
   logic [VW-1:0]                p_ff, p_in;
   logic [2*VW-1:0]              prod_ff, prod_in;
   logic [SW-1:0]                k_ff, k_in;
   logic [CW-1:0]                stored_ff, stored_in;
   logic [CNT_W-1:0]             found_ff, found_in;

   // Query value held while the table read is in flight.
   logic [VW-1:0]                qv_ff, qv_in;

   // Result waiting for the response register to free up.
   logic [lsmf_pkg::VALUE_W-1:0] res_factor_ff, res_factor_in;
   logic                         res_prime_ff, res_prime_in;
   lsmf_pkg::status_type         res_status_ff, res_status_in;

   // Response register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [lsmf_pkg::VALUE_W-1:0] rsp_factor_ff, rsp_factor_in;
   logic                         rsp_prime_ff, rsp_prime_in;
   logic [CNT_W-1:0]             rsp_total_ff, rsp_total_in;
   lsmf_pkg::status_type         rsp_status_ff, rsp_status_in;

   // Memory ports.
   logic                         tbl_we, tbl_re;
   logic [VW-1:0]                tbl_waddr, tbl_wdata, tbl_raddr, tbl_rdata;
   logic                         pl_we, pl_re;
   logic [SW-1:0]                pl_waddr, pl_raddr;
   logic [VW-1:0]                pl_wdata, pl_rdata;

   // Combinational helpers.
   logic                         slot_free;
   logic                         rsp_load;
   logic [lsmf_pkg::VALUE_W-1:0] ld_factor;
   logic                         ld_prime;
   lsmf_pkg::status_type         ld_status;
   logic                         adv;
   logic [LW-1:0]                lim_wide;
   logic [LW-1:0]                qv_wide;
   logic                         is_new;
   logic                         can_store;
   logic [CW-1:0]                stored_next;

   // The smallest-factor table and the ordered prime list.
   lsmf_ram #(
      .DEPTH (MAX_VALUE + 1),
      .WIDTH (VW)
   ) u_factor_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_en   (tbl_re),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata)
   );

   lsmf_ram #(
      .DEPTH (PRIME_SLOTS),
      .WIDTH (VW)
   ) u_prime_list (
      .clock   (clock),
      .wr_en   (pl_we),
      .wr_addr (pl_waddr),
      .wr_data (pl_wdata),
      .rd_en   (pl_re),
      .rd_addr (pl_raddr),
      .rd_data (pl_rdata)
   );

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      state_in       = state_ff;
      sieve_limit_in = sieve_limit_ff;
      built_limit_in = built_limit_ff;
      table_ready_in = table_ready_ff;
      prime_count_in = prime_count_ff;
      lim_in         = lim_ff;
      idx_in         = idx_ff;
      fac_in         = fac_ff;
      p_in           = p_ff;
      prod_in        = prod_ff;
      k_in           = k_ff;
      stored_in      = stored_ff;
      found_in       = found_ff;
      qv_in          = qv_ff;
      res_factor_in  = res_factor_ff;
      res_prime_in   = res_prime_ff;
      res_status_in  = res_status_ff;

      tbl_we    = 1'b0;
      tbl_waddr = idx_ff;
      tbl_wdata = '0;
      tbl_re    = 1'b0;
      tbl_raddr = idx_ff;
      pl_we     = 1'b0;
      pl_waddr  = stored_ff[SW-1:0];
      pl_wdata  = idx_ff;
      pl_re     = 1'b0;
      pl_raddr  = k_ff;

      req_bus.ready = 1'b0;
      rsp_load      = 1'b0;
      ld_factor     = res_factor_ff;
      ld_prime      = res_prime_ff;
      ld_status     = res_status_ff;
      adv           = 1'b0;

      // The build limit saturates at the largest value the table holds.
      lim_wide = LW'(sieve_limit_ff);
      if (lim_wide > LW'(MAX_VALUE)) begin
         lim_wide = LW'(MAX_VALUE);
      end
      qv_wide = LW'(req_bus.query_value);

      is_new      = (tbl_rdata == '0);
      can_store   = is_new && (stored_ff < CW'(PRIME_SLOTS));
      stored_next = can_store ? (stored_ff + CW'(1)) : stored_ff;

      if (csr_write_en) begin
         sieve_limit_in = csr_write_data;
      end

      case (state_ff)
         S_IDLE: begin
            req_bus.ready = 1'b1;
            tbl_raddr     = VW'(req_bus.query_value);
            if (req_bus.valid) begin
               res_factor_in = '0;
               res_prime_in  = 1'b0;
               res_status_in = lsmf_pkg::STATUS_OK;
               if (req_bus.opcode == lsmf_pkg::OP_BUILD) begin
                  lim_in = VW'(lim_wide);
                  if (lim_wide < LW'(lsmf_pkg::FIRST_PRIME)) begin
                     // Nothing to sieve: the table counts as built and empty.
                     built_limit_in = VW'(lim_wide);
                     table_ready_in = 1'b1;
                     prime_count_in = '0;
                     state_in       = S_SEND;
                  end else begin
                     idx_in    = VW'(lsmf_pkg::FIRST_PRIME);
                     stored_in = '0;
                     found_in  = '0;
                     state_in  = S_CLEAR;
                  end
               end else if (!table_ready_ff) begin
                  res_status_in = lsmf_pkg::STATUS_UNBUILT;
                  state_in      = S_SEND;
               end else if (qv_wide < LW'(lsmf_pkg::FIRST_PRIME) ||
                            qv_wide > LW'(built_limit_ff)) begin
                  res_status_in = lsmf_pkg::STATUS_RANGE;
                  state_in      = S_SEND;
               end else begin
                  tbl_re   = 1'b1;
                  qv_in    = VW'(req_bus.query_value);
                  state_in = S_QUERY_RD;
               end
            end
         end

         S_CLEAR: begin
            tbl_we    = 1'b1;
            tbl_waddr = idx_ff;
            tbl_wdata = '0;
            if (idx_ff == lim_ff) begin
               idx_in   = VW'(lsmf_pkg::FIRST_PRIME);
               state_in = S_VISIT_RD;
            end else begin
               idx_in = idx_ff + VW'(1);
            end
         end

         S_VISIT_RD: begin
            tbl_re    = 1'b1;
            tbl_raddr = idx_ff;
            state_in  = S_VISIT_CHK;
         end

         S_VISIT_CHK: begin
            k_in      = '0;
            stored_in = stored_next;
            if (is_new) begin
               // Unmarked means prime: it is its own smallest factor.
               fac_in    = idx_ff;
               tbl_we    = 1'b1;
               tbl_waddr = idx_ff;
               tbl_wdata = idx_ff;
               if (found_ff < lsmf_pkg::COUNT_MAX) begin
                  found_in = found_ff + CNT_W'(1);
               end
               if (can_store) begin
                  pl_we    = 1'b1;
                  pl_waddr = stored_ff[SW-1:0];
                  pl_wdata = idx_ff;
               end
            end else begin
               fac_in = tbl_rdata;
            end
            if (stored_next == '0) begin
               adv = 1'b1;
            end else begin
               state_in = S_LIST_RD;
            end
         end

         S_LIST_RD: begin
            pl_re    = 1'b1;
            pl_raddr = k_ff;
            state_in = S_MUL;
         end

         S_MUL: begin
            p_in     = pl_rdata;
            prod_in  = {{VW{1'b0}}, pl_rdata} * {{VW{1'b0}}, idx_ff};
            state_in = S_MARK;
         end

         S_MARK: begin
            if (prod_ff > {{VW{1'b0}}, lim_ff}) begin
               adv = 1'b1;
            end else begin
               tbl_we    = 1'b1;
               tbl_waddr = prod_ff[VW-1:0];
               tbl_wdata = p_ff;
               // The walk stops once p reaches the smallest factor of i, or at the last stored prime.
               if (p_ff == fac_ff || (CW'(k_ff) + CW'(1)) == stored_ff) begin
                  adv = 1'b1;
               end else begin
                  k_in     = k_ff + SW'(1);
                  state_in = S_LIST_RD;
               end
            end
         end

         S_QUERY_RD: begin
            res_factor_in = lsmf_pkg::VALUE_W'(tbl_rdata);
            res_prime_in  = (tbl_rdata == qv_ff);
            res_status_in = lsmf_pkg::STATUS_OK;
            if (slot_free) begin
               rsp_load  = 1'b1;
               ld_factor = lsmf_pkg::VALUE_W'(tbl_rdata);
               ld_prime  = (tbl_rdata == qv_ff);
               ld_status = lsmf_pkg::STATUS_OK;
               state_in  = S_IDLE;
            end else begin
               state_in = S_SEND;
            end
         end

         S_SEND: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Move on to the next value, or finish the build after the limit.
      if (adv) begin
         if (idx_ff == lim_ff) begin
            built_limit_in = lim_ff;
            table_ready_in = 1'b1;
            prime_count_in = found_in;
            state_in       = S_SEND;
         end else begin
            idx_in   = idx_ff + VW'(1);
            state_in = S_VISIT_RD;
         end
      end

      rsp_factor_in = rsp_factor_ff;
      rsp_prime_in  = rsp_prime_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_factor_in = ld_factor;
         rsp_prime_in  = ld_prime;
         rsp_total_in  = prime_count_ff;
         rsp_status_in = ld_status;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         sieve_limit_ff <= lsmf_pkg::SIEVE_LIMIT_RESET;
         built_limit_ff <= '0;
         table_ready_ff <= 1'b0;
         prime_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         sieve_limit_ff <= sieve_limit_in;
         built_limit_ff <= built_limit_in;
         table_ready_ff <= table_ready_in;
         prime_count_ff <= prime_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      lim_ff        <= lim_in;
      idx_ff        <= idx_in;
      fac_ff        <= fac_in;
      p_ff          <= p_in;
      prod_ff       <= prod_in;
      k_ff          <= k_in;
      stored_ff     <= stored_in;
      found_ff      <= found_in;
      qv_ff         <= qv_in;
      res_factor_ff <= res_factor_in;
      res_prime_ff  <= res_prime_in;
      res_status_ff <= res_status_in;
      rsp_factor_ff <= rsp_factor_in;
      rsp_prime_ff  <= rsp_prime_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.smallest_factor = rsp_factor_ff;
   assign rsp_bus.is_prime        = rsp_prime_ff;
   assign rsp_bus.prime_total     = rsp_total_ff;
   assign rsp_bus.status          = rsp_status_ff;

endmodule

`default_nettype wire
